// ----- rtl/serial_port_ring_buffers_with_echo_unit_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef SERIAL_PORT_RING_BUFFERS_WITH_ECHO_UNIT_MACROS_SVH
`define SERIAL_PORT_RING_BUFFERS_WITH_ECHO_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sprb_pkg.sv -----
package sprb_pkg;

    localparam int RX_DEPTH = 512;
    localparam int TX_DEPTH = 512;

    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

    localparam int LEVEL_W = 10;

    typedef logic [7:0]         t_byte;
    typedef logic [LEVEL_W-1:0] t_level;

    typedef enum logic [1:0] {
        MODE_LINE_RX  = 2'd0,
        MODE_TX_READY = 2'd1,
        MODE_SW_WRITE = 2'd2,
        MODE_SW_READ  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode mode;
        t_byte data_byte;
    } t_in_item;

    typedef struct packed {
        t_byte  out_byte;
        logic   out_valid;
        logic   write_accepted;
        t_level rx_fill_level;
        t_level tx_fill_level;
        logic   tx_armed;
    } t_out_item;

endpackage

// ----- rtl/sprb_ram.sv -----
module sprb_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/serial_port_ring_buffers_with_echo_unit.sv -----
// Receive and transmit byte rings of a serial port, with optional echo.
//
// Input channel: i_item (mode, data_byte) is taken at a rising edge with
// start high and busy low. busy is always low: every cycle can take an item.
// Result channel: one result per item, on o_result for exactly one cycle
// with o_strobe high, in the cycle after the item was taken. The receiver has
// no way to stall; results are simply presented.
// Throughput is one item per clock. Pointers and counts are updated at the
// accepting edge; the ring memories are single write / single read RAMs with
// a registered read whose output feeds the result byte directly.
// A byte written to a ring is visible to a read issued the very next cycle,
// so no forwarding path is needed.
// Configuration: i_cfg_we writes i_cfg_wdata into the echo enable register,
// any time the block is idle.
// Reset (synchronous, active low): both rings empty, transmit disarmed,
// echo enabled. No memory clearing pass; ring contents are don't-care
// until written.

`include "serial_port_ring_buffers_with_echo_unit_macros.svh"

module serial_port_ring_buffers_with_echo_unit
    import sprb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
    localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);
    localparam logic [RX_CNT_W-1:0] RX_FULL = RX_CNT_W'(RX_DEPTH);
    localparam logic [TX_CNT_W-1:0] TX_FULL = TX_CNT_W'(TX_DEPTH);

    logic                r_echo;
    logic [RX_PTR_W-1:0] r_rx_wr, n_rx_wr, r_rx_rd, n_rx_rd;
    logic [RX_CNT_W-1:0] r_rx_count, n_rx_count;
    logic [TX_PTR_W-1:0] r_tx_wr, n_tx_wr, r_tx_rd, n_tx_rd;
    logic [TX_CNT_W-1:0] r_tx_count, n_tx_count;
    logic                r_armed, n_armed;

    logic r_strobe;
    logic r_valid, n_valid;
    logic r_accepted, n_accepted;
    logic r_sel_tx, n_sel_tx;

    logic  accept;
    logic  rx_we, rx_re, tx_we, tx_re;
    t_byte rx_rdata, tx_rdata;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        n_rx_wr    = r_rx_wr;
        n_rx_rd    = r_rx_rd;
        n_rx_count = r_rx_count;
        n_tx_wr    = r_tx_wr;
        n_tx_rd    = r_tx_rd;
        n_tx_count = r_tx_count;
        n_armed    = r_armed;
        n_valid    = 1'b0;
        n_accepted = 1'b0;
        n_sel_tx   = 1'b0;
        rx_we      = 1'b0;
        rx_re      = 1'b0;
        tx_we      = 1'b0;
        tx_re      = 1'b0;
        if (accept) begin
            case (i_item.mode)
                MODE_LINE_RX: begin
                    rx_we   = 1'b1;
                    n_rx_wr = (r_rx_wr == RX_LAST) ? '0 : r_rx_wr + 1'b1;
                    // full ring: drop the oldest byte
                    if (r_rx_count == RX_FULL) begin
                        n_rx_rd = (r_rx_rd == RX_LAST) ? '0 : r_rx_rd + 1'b1;
                    end else begin
                        n_rx_count = r_rx_count + 1'b1;
                    end
                    if (r_echo) begin
                        tx_we   = 1'b1;
                        n_armed = 1'b1;
                        n_tx_wr = (r_tx_wr == TX_LAST) ? '0 : r_tx_wr + 1'b1;
                        if (r_tx_count == TX_FULL) begin
                            n_tx_rd = (r_tx_rd == TX_LAST) ? '0 : r_tx_rd + 1'b1;
                        end else begin
                            n_tx_count = r_tx_count + 1'b1;
                        end
                    end
                end
                MODE_TX_READY: begin
                    if (r_armed) begin
                        if (r_tx_count != '0) begin
                            tx_re      = 1'b1;
                            n_valid    = 1'b1;
                            n_sel_tx   = 1'b1;
                            n_tx_count = r_tx_count - 1'b1;
                            n_tx_rd    = (r_tx_rd == TX_LAST) ? '0 : r_tx_rd + 1'b1;
                        end else begin
                            n_armed = 1'b0;
                        end
                    end
                end
                MODE_SW_WRITE: begin
                    n_armed = 1'b1;
                    if (r_tx_count != TX_FULL) begin
                        tx_we      = 1'b1;
                        n_accepted = 1'b1;
                        n_tx_count = r_tx_count + 1'b1;
                        n_tx_wr    = (r_tx_wr == TX_LAST) ? '0 : r_tx_wr + 1'b1;
                    end
                end
                MODE_SW_READ: begin
                    if (r_rx_count != '0) begin
                        rx_re      = 1'b1;
                        n_valid    = 1'b1;
                        n_rx_count = r_rx_count - 1'b1;
                        n_rx_rd    = (r_rx_rd == RX_LAST) ? '0 : r_rx_rd + 1'b1;
                    end
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo     <= 1'b1;
            r_rx_wr    <= '0;
            r_rx_rd    <= '0;
            r_rx_count <= '0;
            r_tx_wr    <= '0;
            r_tx_rd    <= '0;
            r_tx_count <= '0;
            r_armed    <= 1'b0;
            r_strobe   <= 1'b0;
            r_valid    <= 1'b0;
            r_accepted <= 1'b0;
            r_sel_tx   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_echo <= i_cfg_wdata;
            end
            r_rx_wr    <= n_rx_wr;
            r_rx_rd    <= n_rx_rd;
            r_rx_count <= n_rx_count;
            r_tx_wr    <= n_tx_wr;
            r_tx_rd    <= n_tx_rd;
            r_tx_count <= n_tx_count;
            r_armed    <= n_armed;
            r_strobe   <= accept;
            r_valid    <= n_valid;
            r_accepted <= n_accepted;
            r_sel_tx   <= n_sel_tx;
        end
    end

    sprb_ram #(
        .DEPTH (RX_DEPTH),
        .WIDTH (8)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_wr),
        .i_wdata (i_item.data_byte),
        .i_re    (rx_re),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_rdata)
    );

    sprb_ram #(
        .DEPTH (TX_DEPTH),
        .WIDTH (8)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_wr),
        .i_wdata (i_item.data_byte),
        .i_re    (tx_re),
        .i_raddr (r_tx_rd),
        .o_rdata (tx_rdata)
    );

    // levels and arm flag already hold the post-item values during the strobe
    assign o_strobe                = r_strobe;
    assign o_result.out_byte       = r_valid ? (r_sel_tx ? tx_rdata : rx_rdata) : '0;
    assign o_result.out_valid      = r_valid;
    assign o_result.write_accepted = r_accepted;
    assign o_result.rx_fill_level  = LEVEL_W'(r_rx_count);
    assign o_result.tx_fill_level  = LEVEL_W'(r_tx_count);
    assign o_result.tx_armed       = r_armed;

    `SPRB_ASSERT_NOW(a_rx_count_bound, 1'b1, r_rx_count <= RX_FULL,
        "receive count beyond ring depth")
    `SPRB_ASSERT_NOW(a_tx_count_bound, 1'b1, r_tx_count <= TX_FULL,
        "transmit count beyond ring depth")
    `SPRB_ASSERT_NEXT(a_one_result, accept, o_strobe,
        "taken item gave no result strobe")
    `SPRB_ASSERT_NEXT(a_empty_read,
        accept && i_item.mode == MODE_SW_READ && r_rx_count == '0,
        !o_result.out_valid && o_result.rx_fill_level == '0,
        "read of empty receive ring returned a byte")
    `SPRB_ASSERT_NEXT(a_disarm,
        accept && i_item.mode == MODE_TX_READY && r_tx_count == '0,
        !o_result.tx_armed && !o_result.out_valid,
        "transmitter ready on empty ring left transmit armed")

endmodule

// ----- sim/serial_port_ring_buffers_with_echo_unit_tb.sv -----
module serial_port_ring_buffers_with_echo_unit_tb;
    import sprb_pkg::*;

    localparam int RING_RX = 0;
    localparam int RING_TX = 1;
    localparam int RING_MAX = (RX_DEPTH > TX_DEPTH) ? RX_DEPTH : TX_DEPTH;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT = 200000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_strobe;
    t_out_item o_result;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_wdata = 1'b0;

    serial_port_ring_buffers_with_echo_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of both rings, indexed by RING_RX / RING_TX
    t_byte ring_mem [2][RING_MAX];
    int    ring_wr  [2];
    int    ring_rd  [2];
    int    ring_cnt [2];
    logic  tx_armed_q = 1'b0;
    logic  echo_on = 1'b1;

    t_in_item  byte_events[$];
    t_out_item predicted_port_status[$];
    t_out_item want;

    int err_count = 0;
    int cycle_count = 0;
    int idle_left = 0;
    int burst_left = 0;

    function automatic int ring_depth(int r);
        return (r == RING_RX) ? RX_DEPTH : TX_DEPTH;
    endfunction

    // full ring: overwrite the oldest byte, count stays at depth
    function automatic void ring_push(int r, t_byte b);
        ring_mem[r][ring_wr[r]] = b;
        ring_wr[r] = (ring_wr[r] + 1) % ring_depth(r);
        if (ring_cnt[r] >= ring_depth(r))
            ring_rd[r] = (ring_rd[r] + 1) % ring_depth(r);
        else
            ring_cnt[r]++;
    endfunction

    function automatic t_byte ring_pop(int r);
        t_byte b;
        b = ring_mem[r][ring_rd[r]];
        ring_rd[r] = (ring_rd[r] + 1) % ring_depth(r);
        ring_cnt[r]--;
        return b;
    endfunction

    function automatic t_out_item port_step(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.mode)
            MODE_LINE_RX: begin
                ring_push(RING_RX, it.data_byte);
                if (echo_on) begin
                    ring_push(RING_TX, it.data_byte);
                    tx_armed_q = 1'b1;
                end
            end
            MODE_TX_READY: begin
                if (tx_armed_q) begin
                    if (ring_cnt[RING_TX] != 0) begin
                        r.out_byte  = ring_pop(RING_TX);
                        r.out_valid = 1'b1;
                    end else begin
                        tx_armed_q = 1'b0;
                    end
                end
            end
            MODE_SW_WRITE: begin
                if (ring_cnt[RING_TX] < ring_depth(RING_TX)) begin
                    ring_push(RING_TX, it.data_byte);
                    r.write_accepted = 1'b1;
                end
                // arms even when the byte was dropped
                tx_armed_q = 1'b1;
            end
            default: begin
                if (ring_cnt[RING_RX] != 0) begin
                    r.out_byte  = ring_pop(RING_RX);
                    r.out_valid = 1'b1;
                end
            end
        endcase
        r.rx_fill_level = t_level'(ring_cnt[RING_RX]);
        r.tx_fill_level = t_level'(ring_cnt[RING_TX]);
        r.tx_armed      = tx_armed_q;
        return r;
    endfunction

    // mostly back-to-back or short gaps, a few long ones, now and then a
    // stretch with no gaps at all
    function automatic int next_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic void check_field(string name, logic [15:0] exp, logic [15:0] act);
        if (act !== exp) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            err_count++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                predicted_port_status.push_back(port_step(i_item));
            if (start && busy) begin
                // item not taken yet, hold it
            end else if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (byte_events.size() != 0) begin
                i_item <= byte_events.pop_front();
                start <= 1'b1;
                idle_left = next_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (predicted_port_status.size() == 0) begin
                $error("result strobe with no item outstanding");
                err_count++;
            end else begin
                want = predicted_port_status.pop_front();
                check_field("out_byte", want.out_byte, o_result.out_byte);
                check_field("out_valid", want.out_valid, o_result.out_valid);
                check_field("write_accepted", want.write_accepted, o_result.write_accepted);
                check_field("rx_fill_level", want.rx_fill_level, o_result.rx_fill_level);
                check_field("tx_fill_level", want.tx_fill_level, o_result.tx_fill_level);
                check_field("tx_armed", want.tx_armed, o_result.tx_armed);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void queue_event(t_mode m, t_byte d);
        t_in_item it;
        it.mode      = m;
        it.data_byte = d;
        byte_events.push_back(it);
    endfunction

    // percentages for line byte, software write and tx ready; rest are reads
    function automatic void queue_random(int n, int pct_line, int pct_wr, int pct_rdy);
        int roll;
        t_mode m;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 999);
            if (roll < pct_line * 10)
                m = MODE_LINE_RX;
            else if (roll < (pct_line + pct_wr) * 10)
                m = MODE_SW_WRITE;
            else if (roll < (pct_line + pct_wr + pct_rdy) * 10)
                m = MODE_TX_READY;
            else
                m = MODE_SW_READ;
            queue_event(m, t_byte'($urandom_range(0, 255)));
        end
    endfunction

    task automatic wait_drained();
        while (byte_events.size() != 0 || start || predicted_port_status.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_echo(logic v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        echo_on = v;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_echo(1'b1);
        queue_event(MODE_TX_READY, 8'hFF);  // not armed yet
        queue_event(MODE_SW_READ, 8'hFF);   // rx empty
        queue_event(MODE_LINE_RX, 8'h00);
        queue_event(MODE_LINE_RX, 8'hFF);
        queue_event(MODE_TX_READY, 8'h00);
        queue_event(MODE_TX_READY, 8'h00);
        queue_event(MODE_TX_READY, 8'h00);  // empty while armed, disarms
        queue_event(MODE_TX_READY, 8'h00);
        queue_event(MODE_SW_WRITE, 8'hA5);
        queue_event(MODE_SW_WRITE, 8'h5A);
        queue_event(MODE_SW_WRITE, 8'hFF);
        queue_event(MODE_SW_WRITE, 8'h00);
        queue_event(MODE_TX_READY, 8'hFF);
        queue_event(MODE_TX_READY, 8'h00);
        queue_event(MODE_TX_READY, 8'hFF);
        queue_event(MODE_TX_READY, 8'h00);
        queue_event(MODE_TX_READY, 8'hFF);
        queue_event(MODE_SW_READ, 8'h00);
        queue_event(MODE_SW_READ, 8'hFF);
        queue_event(MODE_SW_READ, 8'h00);
        wait_drained();

        // echo on, line-heavy: both rings fill, wrap and overwrite, and
        // software writes start getting dropped
        queue_random(580, 93, 4, 2);
        wait_drained();

        // echo off: pop from both rings, line bytes go to rx only
        write_echo(1'b0);
        queue_random(70, 15, 10, 35);
        wait_drained();

        write_echo(1'b1);
        queue_random(30, 25, 25, 25);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sprb_pkg.sv
rtl/sprb_ram.sv
rtl/serial_port_ring_buffers_with_echo_unit.sv
sim/serial_port_ring_buffers_with_echo_unit_tb.sv
